### src/dlfu_pkg.sv
package dlfu_pkg;

   localparam logic [7:0] CMD_START   = 8'd254;
   localparam logic [7:0] CMD_END     = 8'd253;
   localparam logic [7:0] CMD_HOME    = 8'd72;
   localparam logic [7:0] CMD_GOTO    = 8'd71;
   localparam logic [7:0] GLYPH_LIMIT = 8'd16;
   localparam logic [7:0] SPACE_CHAR  = 8'h20;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [6:0] COLUMNS_RESET = 7'd20;
   localparam logic [4:0] ROWS_RESET    = 5'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLUMNS = 1'b0,
      CSR_ROWS    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] ch;
      logic [7:0] col;
      logic [7:0] row;
      logic       first;
   } item_type;

   function automatic logic [2:0] seq_len(input logic repos, input logic first);
      logic [2:0] n;
      if (!repos) begin
         n = 3'd1;
      end else if (first) begin
         n = 3'd4;
      end else begin
         n = 3'd6;
      end
      return n;
   endfunction

   function automatic logic [7:0] seq_byte(input logic [2:0] k, input logic repos,
                                           input item_type it);
      logic [7:0] b;
      b = it.ch;
      if (repos) begin
         if (it.first) begin
            case (k)
               3'd0:    b = CMD_START;
               3'd1:    b = CMD_HOME;
               3'd2:    b = CMD_END;
               default: b = it.ch;
            endcase
         end else begin
            case (k)
               3'd0:    b = CMD_START;
               3'd1:    b = CMD_GOTO;
               3'd2:    b = it.col;
               3'd3:    b = it.row;
               3'd4:    b = CMD_END;
               default: b = it.ch;
            endcase
         end
      end
      return b;
   endfunction

endpackage

### src/dlfu_shadow_mem.sv
module dlfu_shadow_mem #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [7:0]        wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [7:0]        rdata
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   // read returns the old contents when the same entry is written
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/dlfu_front.sv
module dlfu_front import dlfu_pkg::*; #(
   parameter int  MAX_COLS = 64,
   parameter int  MAX_ROWS = 16,
   localparam int DEPTH    = MAX_ROWS * MAX_COLS,
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,
   input  logic                        take,
   output logic                        s1_vld,
   output item_type                    s1_item,
   output logic                        mem_we,
   output logic [ADDR_W-1:0]           mem_waddr,
   output logic [7:0]                  mem_wdata,
   output logic                        mem_re,
   output logic [ADDR_W-1:0]           mem_raddr
);

   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   logic              clr_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic              zero_seen_ff;
   logic              s1_vld_ff;
   item_type          item_ff;
   logic [6:0]        columns_ff;
   logic [4:0]        rows_ff;

   logic              accept;
   logic [8:0]        ncols;
   logic [8:0]        nrows;
   logic              col_wrap;
   logic              row_wrap;
   logic [ADDR_W-1:0] idx;
   logic              zs_in;

   assign req_tready = !clr_ff && (!s1_vld_ff || take);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (columns_ff == 7'd0) begin
         ncols = 9'd1;
      end else if (9'(columns_ff) > 9'(MAX_COLS)) begin
         ncols = 9'(MAX_COLS);
      end else begin
         ncols = 9'(columns_ff);
      end
      if (rows_ff == 5'd0) begin
         nrows = 9'd1;
      end else if (9'(rows_ff) > 9'(MAX_ROWS)) begin
         nrows = 9'(MAX_ROWS);
      end else begin
         nrows = 9'(rows_ff);
      end
   end

   assign col_wrap = (9'(col_ff) + 9'd1) >= ncols;
   assign row_wrap = (9'(row_ff) + 9'd1) >= nrows;
   assign idx      = ADDR_W'(row_ff) * ADDR_W'(MAX_COLS) + ADDR_W'(col_ff);
   assign zs_in    = zero_seen_ff || (req_tdata == 8'd0);

   assign mem_we    = clr_ff || accept;
   assign mem_waddr = clr_ff ? clr_addr_ff : idx;
   assign mem_wdata = clr_ff ? SPACE_CHAR : (zs_in ? 8'd0 : req_tdata);
   assign mem_re    = accept;
   assign mem_raddr = idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         zero_seen_ff <= 1'b0;
         s1_vld_ff    <= 1'b0;
         columns_ff   <= COLUMNS_RESET;
         rows_ff      <= ROWS_RESET;
      end else begin
         if (clr_ff) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               clr_ff <= 1'b0;
            end
         end
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_COLUMNS: columns_ff <= csr_wdata;
               CSR_ROWS:    rows_ff    <= csr_wdata[4:0];
               default:     ;
            endcase
            col_ff       <= '0;
            row_ff       <= '0;
            zero_seen_ff <= 1'b0;
         end else if (accept) begin
            if (!col_wrap) begin
               col_ff       <= col_ff + COL_W'(1);
               zero_seen_ff <= zs_in;
            end else if (!row_wrap) begin
               col_ff       <= '0;
               row_ff       <= row_ff + ROW_W'(1);
               zero_seen_ff <= zs_in;
            end else begin
               col_ff       <= '0;
               row_ff       <= '0;
               zero_seen_ff <= 1'b0;
            end
         end
         if (accept) begin
            s1_vld_ff <= 1'b1;
         end else if (take) begin
            s1_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.ch    <= req_tdata;
         item_ff.col   <= 8'(col_ff);
         item_ff.row   <= 8'(row_ff);
         item_ff.first <= (col_ff == '0) && (row_ff == '0);
      end
   end

   assign s1_vld  = s1_vld_ff;
   assign s1_item = item_ff;

endmodule

### src/dlfu_emit.sv
module dlfu_emit import dlfu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       s1_vld,
   input  item_type   s1_item,
   input  logic [7:0] rd_data,
   output logic       take,
   input  logic       rsp_tready,
   output logic       rsp_tvalid,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast
);

   logic       repos_ff;
   logic [2:0] k_ff;
   logic       out_vld_ff;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;

   logic       custom;
   logic       skip;
   logic       repos;
   logic [2:0] n;
   logic       is_last;
   logic       out_free;
   logic       load;

   assign custom   = (s1_item.ch != 8'd0) && (s1_item.ch < GLYPH_LIMIT);
   assign skip     = (rd_data == s1_item.ch) && !custom;
   assign repos    = repos_ff || s1_item.first;
   assign n        = seq_len(repos, s1_item.first);
   assign is_last  = (k_ff == n - 3'd1);
   assign out_free = !out_vld_ff || rsp_tready;
   assign load     = s1_vld && !skip && out_free;
   assign take     = s1_vld && (skip || (out_free && is_last));

   always_ff @(posedge clock) begin
      if (reset) begin
         repos_ff   <= 1'b1;
         k_ff       <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         if (load) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
         if (s1_vld && skip) begin
            repos_ff <= 1'b1;
         end else if (load) begin
            if (is_last) begin
               k_ff     <= '0;
               repos_ff <= 1'b0;
            end else begin
               k_ff <= k_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= seq_byte(k_ff, repos, s1_item);
         out_last_ff <= is_last;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

### src/differential_lcd_frame_update_top.sv
// path: item and shadow read are registered, then each output byte is registered
// throughput: one transaction per cycle when skipped or sent without a cursor
// command; 4 or 6 bytes when a cursor command precedes it (one byte per cycle out;
// output waits while rsp_tready is low). reset: synchronous, active high; the
// MAX_ROWS*MAX_COLS shadow entries are then set to spaces, accepting no transaction
module differential_lcd_frame_update_top import dlfu_pkg::*; #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // cell_char
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // out_byte
   output logic                  rsp_tlast
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic              take;
   logic              s1_vld;
   item_type          s1_item;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic [7:0]        rd_data;

   dlfu_front #(
      .MAX_COLS(MAX_COLS),
      .MAX_ROWS(MAX_ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .s1_vld     (s1_vld),
      .s1_item    (s1_item),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr)
   );

   dlfu_shadow_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (rd_data)
   );

   dlfu_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .s1_vld     (s1_vld),
      .s1_item    (s1_item),
      .rd_data    (rd_data),
      .take       (take),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
